// ----- hw/rtl/page_framebuffer_run_engine_core_assert.svh -----
// assertion macros shared by the frame buffer run engine
`ifndef PAGE_FRAMEBUFFER_RUN_ENGINE_CORE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_RUN_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PFRE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pfre same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define PFRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pfre next-cycle check failed");

`endif

// ----- hw/rtl/pfre_pkg.sv -----
// shared constants, codes and control structs of the frame buffer run engine
`timescale 1ns / 1ps
`default_nettype none
package pfre_pkg;
	// panel geometry
	localparam int WIDTH_PX    = 128;
	localparam int HEIGHT_PX   = 64;
	localparam int PAGES       = (HEIGHT_PX + 7) / 8;
	localparam int STORE_BYTES = WIDTH_PX * PAGES;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;

	// pixels per user byte
	localparam int MAX_PIX = 8;
	localparam int CNT_W   = 4;
	localparam int PIX_W   = 3;

	// panel command bytes
	localparam logic [7:0] CMD_PAGE     = 8'hB0;
	localparam logic [7:0] CMD_COL_LO   = 8'h00;
	localparam logic [7:0] CMD_COL_HI   = 8'h10;
	localparam logic [7:0] LOW_NIBBLE   = 8'h0f;
	localparam logic [7:0] BIT_FIRST_LS = 8'h01;
	localparam logic [7:0] BIT_FIRST_MS = 8'h80;

	// input item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// position command sequence
	localparam logic [1:0] POS_PAGE   = 2'd0;
	localparam logic [1:0] POS_COL_LO = 2'd1;
	localparam logic [1:0] POS_COL_HI = 2'd2;

	// result kinds
	typedef enum logic [1:0] {
		OUT_CMD  = 2'd0,
		OUT_DATA = 2'd1,
		OUT_READ = 2'd2,
		OUT_ERR  = 2'd3
	} out_kind_t;

	// controller to datapath
	typedef struct packed {
		logic      load;
		logic      clr_step;
		logic      rd_issue;
		logic      rd_next;
		logic      acc;
		logic      wr_pix;
		logic      emit;
		out_kind_t emit_kind;
		logic      emit_last;
		logic      pix_inc;
		logic      cmd_inc;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic is_err;
		logic is_empty;
		logic is_read;
		logic first;
		logic pix_last;
		logic cmd_last;
		logic out_free;
	} dp_sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/pfre_in_if.sv -----
// input item channel of the frame buffer run engine
`timescale 1ns / 1ps
`default_nettype none
interface pfre_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] row;
	logic [7:0] col;
	logic [3:0] pixel_count;
	logic [7:0] pixel_bits;
	logic       first_of_run;

	modport source (
		output valid, kind, row, col, pixel_count, pixel_bits, first_of_run,
		input  ready
	);
	modport sink (
		input  valid, kind, row, col, pixel_count, pixel_bits, first_of_run,
		output ready
	);
endinterface
`default_nettype wire

// ----- hw/rtl/pfre_out_if.sv -----
// result item channel of the frame buffer run engine
`timescale 1ns / 1ps
`default_nettype none
interface pfre_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       last;

	modport source (
		output valid, out_kind, out_byte, last,
		input  ready
	);
	modport sink (
		input  valid, out_kind, out_byte, last,
		output ready
	);
endinterface
`default_nettype wire

// ----- hw/rtl/page_framebuffer_run_engine_core.sv -----
// top level of the page-addressed 1bpp frame buffer run engine
//
// channel   dir  flow          payload
// req       in   valid/ready   kind, row, col, pixel_count, pixel_bits, first_of_run
// rsp       out  valid/ready   out_kind, out_byte, last
// cfg       in   write only    cfg_wdata (msb_first) on cfg_we
//
// one item at a time: an item is accepted in IDLE and decoded in DISP, then each
// result is sent, or each store byte read, in its own step of the sequencer.
// the single-port-per-direction frame store does one read-modify-write a cycle while rsp does not stall.
// after reset a clearing pass zeroes every store byte; req.ready stays low.
// a stalled rsp holds the sequencer; the result register lets req take the next
// item while the last result of an item still waits.
`timescale 1ns / 1ps
`default_nettype none
`include "page_framebuffer_run_engine_core_assert.svh"
module page_framebuffer_run_engine_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pfre_in_if.sink    req,
	pfre_out_if.source rsp,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata
);
	pfre_pkg::ctrl_cmd_t cmd;
	pfre_pkg::dp_sts_t   sts;
	logic                in_ready;

	// sequencer
	pfre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store and result datapath
	pfre_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.kind         (req.kind),
		.row          (req.row),
		.col          (req.col),
		.pixel_count  (req.pixel_count),
		.pixel_bits   (req.pixel_bits),
		.first_of_run (req.first_of_run),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_kind     (rsp.out_kind),
		.out_byte     (rsp.out_byte),
		.last         (rsp.last)
	);

	assign req.ready = in_ready;

	// no item taken while the store is being cleared
	`PFRE_ASSERT_NOW(a_no_accept_in_clear, clk, arst_n, cmd.clr_step, !req.ready)
	// a result is only loaded when the result register can take it
	`PFRE_ASSERT_NOW(a_emit_when_free, clk, arst_n, cmd.emit, sts.out_free)
	// every pixel write to the store loads a result in the same cycle
	`PFRE_ASSERT_NOW(a_write_with_emit, clk, arst_n, cmd.wr_pix, cmd.emit && !cmd.clr_step)
	// one item at a time
	`PFRE_ASSERT_NEXT(a_one_item, clk, arst_n, req.valid && req.ready, !req.ready)
endmodule
`default_nettype wire

// ----- hw/rtl/pfre_ctrl.sv -----
// controller state machine of the frame buffer run engine
`timescale 1ns / 1ps
`default_nettype none
module pfre_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pfre_pkg::dp_sts_t  sts,
	output pfre_pkg::ctrl_cmd_t     cmd
);
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISP,
		S_ERR,
		S_RACC,
		S_REMIT,
		S_CMD,
		S_WPIX
	} state_t;

	state_t state_q;
	state_t state_d;

	// command decode and next state
	always_comb begin
		cmd      = '0;
		cmd.emit_kind = pfre_pkg::OUT_ERR;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				// fetch the first covered store byte up front
				cmd.rd_issue = 1'b1;
				priority if (sts.is_err) begin
					state_d = S_ERR;
				end else if (sts.is_empty) begin
					state_d = S_IDLE;
				end else if (sts.is_read) begin
					state_d = S_RACC;
				end else if (sts.first) begin
					state_d = S_CMD;
				end else begin
					state_d = S_WPIX;
				end
			end
			S_ERR: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = pfre_pkg::OUT_ERR;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_RACC: begin
				cmd.acc = 1'b1;
				if (sts.pix_last) begin
					state_d = S_REMIT;
				end else begin
					cmd.rd_issue = 1'b1;
					cmd.rd_next  = 1'b1;
					cmd.pix_inc  = 1'b1;
				end
			end
			S_REMIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = pfre_pkg::OUT_READ;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_CMD: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = pfre_pkg::OUT_CMD;
					cmd.cmd_inc   = 1'b1;
					if (sts.cmd_last) begin
						state_d = S_WPIX;
					end
				end
			end
			S_WPIX: begin
				// one read-modify-write per cycle while the result register is free, next byte fetched alongside
				if (sts.out_free) begin
					cmd.wr_pix    = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_kind = pfre_pkg::OUT_DATA;
					cmd.emit_last = sts.pix_last;
					if (sts.pix_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_issue = 1'b1;
						cmd.rd_next  = 1'b1;
						cmd.pix_inc  = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/pfre_dp.sv -----
// datapath of the frame buffer run engine: item registers, store, result register
`timescale 1ns / 1ps
`default_nettype none
module pfre_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                kind,
	input  wire logic [7:0]          row,
	input  wire logic [7:0]          col,
	input  wire logic [3:0]          pixel_count,
	input  wire logic [7:0]          pixel_bits,
	input  wire logic                first_of_run,
	input  wire pfre_pkg::ctrl_cmd_t cmd,
	output pfre_pkg::dp_sts_t        sts,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               out_kind,
	output logic [7:0]               out_byte,
	output logic                     last
);
	localparam int AW = pfre_pkg::ADDR_W;
	localparam int CW = pfre_pkg::CNT_W;
	localparam int PW = pfre_pkg::PIX_W;
	localparam int GW = pfre_pkg::PAGE_W;

	// configuration
	logic msb_q;

	// item registers
	logic                 kind_q;
	logic                 err_q;
	logic                 empty_q;
	logic                 first_q;
	logic [CW-1:0]        len_q;
	logic [GW-1:0]        page_q;
	logic [7:0]           col_q;
	logic [AW-1:0]        base_q;
	logic [7:0]           bits_q;
	logic [2:0]           rowbit_q;

	// sequencing counters
	logic [PW-1:0]        pix_q;
	logic [1:0]           cmd_q;
	logic [AW-1:0]        clr_q;

	// store and its read register
	logic [7:0]           mem_q [pfre_pkg::STORE_BYTES];
	logic [7:0]           rd_q;
	logic [7:0]           packed_q;

	// result register
	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	logic [7:0]           out_byte_q;
	logic                 last_q;

	// load-time decode
	logic [CW-1:0]        cnt_sat;
	logic [8:0]           col9;
	logic [8:0]           sum9;
	logic [CW-1:0]        len_d;
	logic                 row_bad;
	logic [GW-1:0]        page_d;

	// per-pixel logic
	logic [7:0]           ubit;
	logic [7:0]           row_mask;
	logic [7:0]           new_byte;
	logic [CW-1:0]        rd_off;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic                 mem_we;
	logic [7:0]           mem_wdata;
	logic [7:0]           emit_byte;
	logic                 out_free;

	// saturate count, clip the run at the right edge
	always_comb begin
		cnt_sat = (pixel_count > CW'(pfre_pkg::MAX_PIX)) ? CW'(pfre_pkg::MAX_PIX) : pixel_count;
		col9    = {1'b0, col};
		sum9    = col9 + 9'(cnt_sat);
		if (col9 >= 9'(pfre_pkg::WIDTH_PX)) begin
			len_d = '0;
		end else if (sum9 > 9'(pfre_pkg::WIDTH_PX)) begin
			len_d = CW'(9'(pfre_pkg::WIDTH_PX) - col9);
		end else begin
			len_d = cnt_sat;
		end
		row_bad = ({1'b0, row} >= 9'(pfre_pkg::HEIGHT_PX));
		page_d  = row[GW+2:3];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msb_q <= 1'b0;
		end else if (cfg_we) begin
			msb_q <= cfg_wdata;
		end
	end

	// item registers, loaded at accept
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind;
			err_q    <= row_bad || ((kind == pfre_pkg::KIND_READ) && (len_d == '0));
			empty_q  <= (len_d == '0);
			first_q  <= first_of_run;
			len_q    <= len_d;
			page_q   <= page_d;
			col_q    <= col;
			base_q   <= AW'(AW'(page_d) * AW'(pfre_pkg::WIDTH_PX)) + AW'(col);
			bits_q   <= pixel_bits;
			rowbit_q <= row[2:0];
		end
	end

	// pixel and command counters
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q <= '0;
			cmd_q <= pfre_pkg::POS_PAGE;
		end else begin
			if (cmd.pix_inc) begin
				pix_q <= pix_q + PW'(1);
			end
			if (cmd.cmd_inc) begin
				cmd_q <= cmd_q + 2'd1;
			end
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step && (clr_q != AW'(pfre_pkg::STORE_BYTES - 1))) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// user bit of the current pixel and the store bit of the row
	always_comb begin
		ubit     = msb_q ? (pfre_pkg::BIT_FIRST_MS >> pix_q) : (pfre_pkg::BIT_FIRST_LS << pix_q);
		row_mask = pfre_pkg::BIT_FIRST_LS << rowbit_q;
		new_byte = ((bits_q & ubit) != 8'h00) ? (rd_q | row_mask) : (rd_q & ~row_mask);
	end

	// store addressing
	always_comb begin
		rd_off    = cmd.rd_next ? ({1'b0, pix_q} + CW'(1)) : '0;
		rd_addr   = base_q + AW'(rd_off);
		wr_addr   = cmd.clr_step ? clr_q : (base_q + AW'(pix_q));
		mem_we    = cmd.clr_step || cmd.wr_pix;
		mem_wdata = cmd.clr_step ? 8'h00 : new_byte;
	end

	// frame store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= mem_wdata;
		end
		if (cmd.rd_issue) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// read-back packing
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			packed_q <= 8'h00;
		end else if (cmd.acc && ((rd_q & row_mask) != 8'h00)) begin
			packed_q <= packed_q | ubit;
		end
	end

	// result byte select
	always_comb begin
		unique case (cmd.emit_kind)
			pfre_pkg::OUT_CMD: begin
				unique case (cmd_q)
					pfre_pkg::POS_PAGE:   emit_byte = pfre_pkg::CMD_PAGE + 8'(page_q);
					pfre_pkg::POS_COL_LO: emit_byte = pfre_pkg::CMD_COL_LO + (col_q & pfre_pkg::LOW_NIBBLE);
					default:              emit_byte = pfre_pkg::CMD_COL_HI + (col_q >> 4);
				endcase
			end
			pfre_pkg::OUT_DATA: emit_byte = new_byte;
			pfre_pkg::OUT_READ: emit_byte = packed_q;
			default:            emit_byte = 8'h00;
		endcase
	end

	// result register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.emit_kind;
			out_byte_q <= emit_byte;
			last_q     <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	// status to the controller
	always_comb begin
		sts.clr_done = (clr_q == AW'(pfre_pkg::STORE_BYTES - 1));
		sts.is_err   = err_q;
		sts.is_empty = empty_q;
		sts.is_read  = (kind_q == pfre_pkg::KIND_READ);
		sts.first    = first_q;
		sts.pix_last = (({1'b0, pix_q} + CW'(1)) == len_q);
		sts.cmd_last = (cmd_q == pfre_pkg::POS_COL_HI);
		sts.out_free = out_free;
	end
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// self-checking bench for the page-addressed frame buffer run engine
`timescale 1ns / 1ps
module tb_top;
	import pfre_pkg::*;

	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned SETTLE_TICKS = 24;
	localparam int unsigned TAIL_TICKS   = 40;
	localparam int unsigned HOLD_TICKS   = 300;
	localparam int unsigned PHASE_ITEMS  = 62;

	// one pixel run byte on the request channel
	typedef struct packed {
		logic       kind;
		logic [7:0] row;
		logic [7:0] col;
		logic [3:0] pixel_count;
		logic [7:0] pixel_bits;
		logic       first_of_run;
	} pixel_item_t;

	// one byte on the response channel
	typedef struct packed {
		out_kind_t  kind;
		logic [7:0] data;
		logic       last;
	} panel_byte_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_ALWAYS = 2'd0,
		RX_COIN   = 2'd1,
		RX_SPARSE = 2'd2,
		RX_MOSTLY = 2'd3
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	pfre_in_if  req_if ();
	pfre_out_if rsp_if ();

	page_framebuffer_run_engine_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	pixel_item_t  pending_items[$];
	panel_byte_t  panel_bytes_due[$];
	logic [7:0]   shadow_store [STORE_BYTES];
	logic         msb_first_mode;
	int unsigned  mismatch_count = 0;
	int unsigned  items_accepted = 0;
	int unsigned  idle_ticks = 0;

	pixel_item_t  drive_item;
	int unsigned  burst_left;
	int unsigned  gap_left;
	rx_mode_t     rx_mode;
	int unsigned  rx_age;
	int unsigned  hold_left;
	int unsigned  holds_done;
	panel_byte_t  got_want;

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// user byte bit of the i-th pixel of a run
	function automatic logic [7:0] user_bit_mask(int unsigned i);
		return msb_first_mode ? (BIT_FIRST_MS >> i) : (BIT_FIRST_LS << i);
	endfunction

	function automatic void push_due(out_kind_t kind, logic [7:0] data);
		panel_byte_t b;
		b.kind = kind;
		b.data = data;
		b.last = 1'b0;
		panel_bytes_due.push_back(b);
	endfunction

	// update the shadow store and queue the bytes one run item causes
	function automatic void apply_pixel_item(pixel_item_t it);
		int unsigned cnt, len, base, i;
		logic [7:0]  pg, rmask, read_bits;
		panel_byte_t tail;
		cnt = (it.pixel_count > MAX_PIX) ? MAX_PIX : it.pixel_count;
		if (it.col >= WIDTH_PX)
			len = 0;
		else if (it.col + cnt > WIDTH_PX)
			len = WIDTH_PX - it.col;
		else
			len = cnt;
		// out-of-range row or empty read gives a single error byte
		if (it.row >= HEIGHT_PX || (it.kind == KIND_READ && len == 0)) begin
			tail.kind = OUT_ERR;
			tail.data = 8'h00;
			tail.last = 1'b1;
			panel_bytes_due.push_back(tail);
			return;
		end
		if (len == 0)
			return;
		pg = it.row >> 3;
		rmask = 8'h01 << it.row[2:0];
		base = pg * WIDTH_PX + it.col;
		if (it.kind == KIND_READ) begin
			read_bits = 8'h00;
			for (i = 0; i < len; i++)
				if ((shadow_store[base + i] & rmask) != 0)
					read_bits = read_bits | user_bit_mask(i);
			push_due(OUT_READ, read_bits);
		end else begin
			if (it.first_of_run) begin
				push_due(OUT_CMD, CMD_PAGE + pg);
				push_due(OUT_CMD, CMD_COL_LO + (it.col & LOW_NIBBLE));
				push_due(OUT_CMD, CMD_COL_HI + (it.col >> 4));
			end
			for (i = 0; i < len; i++) begin
				if ((it.pixel_bits & user_bit_mask(i)) != 0)
					shadow_store[base + i] = shadow_store[base + i] | rmask;
				else
					shadow_store[base + i] = shadow_store[base + i] & ~rmask;
				push_due(OUT_DATA, shadow_store[base + i]);
			end
		end
		tail = panel_bytes_due.pop_back();
		tail.last = 1'b1;
		panel_bytes_due.push_back(tail);
	endfunction

	// request driver, bursts with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!req_if.valid || req_if.ready) begin
			if (gap_left != 0) begin
				req_if.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_items.size() != 0) begin
				drive_item = pending_items.pop_front();
				req_if.kind <= drive_item.kind;
				req_if.row <= drive_item.row;
				req_if.col <= drive_item.col;
				req_if.pixel_count <= drive_item.pixel_count;
				req_if.pixel_bits <= drive_item.pixel_bits;
				req_if.first_of_run <= drive_item.first_of_run;
				req_if.valid <= 1'b1;
				if (burst_left != 0) begin
					burst_left <= burst_left - 1;
				end else if ($urandom_range(0, 2) == 0) begin
					burst_left <= $urandom_range(10, 40);
					gap_left <= 0;
				end else begin
					burst_left <= $urandom_range(0, 8);
					gap_left <= $urandom_range(1, 12);
				end
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// response receiver, own stall pattern plus long hold-offs
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			rx_mode <= RX_ALWAYS;
			rx_age <= 0;
			hold_left <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			rsp_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && items_accepted >= 80 + holds_done * 120) begin
			rsp_if.ready <= 1'b0;
			hold_left <= HOLD_TICKS;
			holds_done <= holds_done + 1;
		end else begin
			rx_age <= rx_age + 1;
			if (rx_age % 48 == 47)
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_ALWAYS: rsp_if.ready <= 1'b1;
				RX_COIN:   rsp_if.ready <= $urandom_range(0, 1);
				RX_SPARSE: rsp_if.ready <= (rx_age % 4 == 0);
				default:   rsp_if.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// monitor: predict on accepted items, check accepted bytes
	always @(posedge clk) begin
		if (!arst_n) begin
			msb_first_mode = 1'b0;
			for (int a = 0; a < STORE_BYTES; a++)
				shadow_store[a] = 8'h00;
		end else begin
			if (cfg_we)
				msb_first_mode = cfg_wdata;
			if (rsp_if.valid && rsp_if.ready) begin
				if (panel_bytes_due.size() == 0) begin
					$error("unexpected result: out_kind %0d out_byte %02h last %0b",
						rsp_if.out_kind, rsp_if.out_byte, rsp_if.last);
					mismatch_count++;
				end else begin
					got_want = panel_bytes_due.pop_front();
					if (rsp_if.out_kind !== got_want.kind) begin
						$error("out_kind: expected %0d, actual %0d", got_want.kind,
							rsp_if.out_kind);
						mismatch_count++;
					end
					if (rsp_if.out_byte !== got_want.data) begin
						$error("out_byte: expected %02h, actual %02h", got_want.data,
							rsp_if.out_byte);
						mismatch_count++;
					end
					if (rsp_if.last !== got_want.last) begin
						$error("last: expected %0b, actual %0b", got_want.last, rsp_if.last);
						mismatch_count++;
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				apply_pixel_item({req_if.kind, req_if.row, req_if.col, req_if.pixel_count,
					req_if.pixel_bits, req_if.first_of_run});
				items_accepted++;
			end
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_ticks <= 0;
		else
			idle_ticks <= idle_ticks + 1;
		if (idle_ticks >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic push_item(logic kind, logic [7:0] row, logic [7:0] col,
		logic [3:0] cnt, logic [7:0] bits, logic first);
		pixel_item_t it;
		it.kind = kind;
		it.row = row;
		it.col = col;
		it.pixel_count = cnt;
		it.pixel_bits = bits;
		it.first_of_run = first;
		pending_items.push_back(it);
	endtask

	// wait until every item is sent and every byte has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || req_if.valid || panel_bytes_due.size() != 0);
	endtask

	task automatic set_msb_first(logic value);
		wait_drained();
		repeat (SETTLE_TICKS) @(posedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// runs of write bytes with random content, some read back, some noise
	task automatic queue_random_runs(int unsigned n_items);
		int unsigned added, nbytes, b, colv;
		logic [7:0]  row;
		logic        first;
		added = 0;
		while (added < n_items) begin
			if ($urandom_range(0, 99) < 12) begin
				push_item($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 1));
				added++;
			end else begin
				row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, HEIGHT_PX - 1);
				colv = ($urandom_range(0, 4) == 0) ? $urandom_range(WIDTH_PX - 16, 255)
					: $urandom_range(0, WIDTH_PX - 1);
				nbytes = $urandom_range(1, 4);
				for (b = 0; b < nbytes && colv + 8 * b <= 255; b++) begin
					// occasionally a run that starts without position commands
					first = (b == 0) ? ($urandom_range(0, 9) != 0) : 1'b0;
					push_item(KIND_WRITE, row, colv + 8 * b,
						(b == nbytes - 1) ? $urandom_range(1, 8) : 8,
						$urandom_range(0, 255), first);
					added++;
				end
				if ($urandom_range(0, 1) == 1) begin
					for (b = 0; b < nbytes && colv + 8 * b <= 255; b++) begin
						push_item(KIND_READ, row, colv + 8 * b, $urandom_range(1, 8),
							$urandom_range(0, 255), $urandom_range(0, 1));
						added++;
					end
				end
			end
		end
	endtask

	// stimulus and end of run
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_if.valid = 1'b0;
		req_if.kind = KIND_WRITE;
		req_if.row = 8'h00;
		req_if.col = 8'h00;
		req_if.pixel_count = 4'h0;
		req_if.pixel_bits = 8'h00;
		req_if.first_of_run = 1'b0;
		rsp_if.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cfg_wdata <= 1'b0;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;

		// directed, leftmost pixel in bit 0
		push_item(KIND_WRITE, 0, 0, 8, 8'hA5, 1);
		push_item(KIND_READ, 0, 0, 8, 8'h00, 0);
		push_item(KIND_WRITE, 0, 8, 8, 8'h3C, 0);
		push_item(KIND_READ, 0, 8, 8, 8'hFF, 1);
		// clipped at the right edge, count saturated
		push_item(KIND_WRITE, 63, 124, 8, 8'hFF, 1);
		push_item(KIND_WRITE, 63, 127, 15, 8'hFF, 1);
		push_item(KIND_READ, 63, 120, 15, 8'h00, 0);
		// row out of range, both kinds
		push_item(KIND_WRITE, 64, 0, 8, 8'hFF, 1);
		push_item(KIND_READ, 255, 255, 15, 8'hFF, 1);
		// empty writes leave nothing
		push_item(KIND_WRITE, 10, 128, 8, 8'hFF, 1);
		push_item(KIND_WRITE, 10, 5, 0, 8'hFF, 1);
		push_item(KIND_WRITE, 33, 255, 8, 8'h00, 1);
		// empty reads give an error
		push_item(KIND_READ, 10, 200, 3, 8'h00, 0);
		push_item(KIND_READ, 10, 5, 0, 8'h00, 0);
		push_item(KIND_WRITE, 7, 15, 1, 8'h01, 1);
		push_item(KIND_WRITE, 56, 100, 8, 8'h5A, 1);
		push_item(KIND_WRITE, 0, 0, 8, 8'h00, 1);
		push_item(KIND_READ, 0, 0, 8, 8'h00, 0);

		// directed, leftmost pixel in bit 7
		set_msb_first(1'b1);
		push_item(KIND_WRITE, 40, 60, 5, 8'hC8, 1);
		push_item(KIND_READ, 40, 60, 8, 8'h00, 0);
		push_item(KIND_READ, 0, 8, 8, 8'h00, 0);
		push_item(KIND_WRITE, 63, 126, 4, 8'hF0, 1);
		push_item(KIND_READ, 63, 124, 8, 8'h00, 0);

		// random phases, bit order toggled between them
		queue_random_runs(PHASE_ITEMS);
		set_msb_first(1'b0);
		queue_random_runs(PHASE_ITEMS);
		set_msb_first(1'b1);
		queue_random_runs(PHASE_ITEMS);
		set_msb_first(1'b0);
		queue_random_runs(PHASE_ITEMS);

		wait_drained();
		repeat (TAIL_TICKS) @(posedge clk);
		if (mismatch_count == 0 && panel_bytes_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
